@@ sv/kdq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the key debounce, long-press and key queue block.
// No dependencies; used by key_debounce_long_press_queue_top.
package kdq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TICKS      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TICKS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY1_PATTERN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY2_PATTERN      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY3_PATTERN      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_OFFSET = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_OFFSET    = 3'd6;

    // Input word modes
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Fixed result codes
    localparam logic [7:0] CODE_EMPTY = 8'hFF;
    localparam logic [7:0] CODE_NONE  = 8'h00;

    typedef struct packed {
        logic        mode;
        logic [15:0] touch_status;
    } in_word_t;

    typedef struct packed {
        logic       popped_valid;
        logic [7:0] popped_code;
        logic       queue_not_empty;
        logic [3:0] queue_level;
    } out_word_t;

endpackage

@@ sv/key_debounce_long_press_queue_top.sv @@
`timescale 1ns / 1ps
// Result words are registered and valid from the cycle after the word is accepted.
// Throughput: one word per cycle; a new word is taken while the result register
// is empty or being drained in the same cycle, so the output register alone sets the rate.
// Reset (rst_n, asynchronous, active low): scan machine idle, counters and held code zero,
// queue empty, registers at their defaults; queue entries are not cleared.
module key_debounce_long_press_queue_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [kdq_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kdq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  kdq_pkg::in_word_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output kdq_pkg::out_word_t           out_data
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_CAPTURE = 3'd2,
        PH_HOLD    = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef logic [kdq_pkg::PTR_W-1:0]  ptr_t;
    typedef logic [kdq_pkg::FILL_W-1:0] fill_t;

    // Configuration registers
    logic [15:0] settle_ticks_reg;
    logic [15:0] long_press_ticks_reg;
    logic [15:0] key1_pattern_reg;
    logic [15:0] key2_pattern_reg;
    logic [15:0] key3_pattern_reg;
    logic [7:0]  long_press_offset_reg;
    logic [7:0]  release_offset_reg;

    // Scan state
    phase_t      phase_reg, phase_next;
    logic [15:0] settle_count_reg, settle_count_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [7:0]  held_code_reg, held_code_next;

    // Queue state
    logic [7:0]  queue_mem [kdq_pkg::QUEUE_DEPTH];
    ptr_t        wr_ptr_reg, wr_ptr_next;
    ptr_t        rd_ptr_reg, rd_ptr_next;
    fill_t       fill_reg, fill_next;

    // Result register
    logic        out_valid_reg;
    logic        popped_valid_reg;
    logic [7:0]  code_reg;
    logic [7:0]  rd_data_reg;
    logic        not_empty_reg;
    logic [3:0]  level_reg;

    // Per-word decode
    logic        in_fire;
    logic        is_pop;
    logic        key_down;
    logic [1:0]  key_code;
    logic        push_en;
    logic [7:0]  push_code;
    logic        push_ok;
    logic        pop_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_pop   = (in_data.mode == kdq_pkg::MODE_POP);
    assign key_down = (in_data.touch_status[7:0] != 8'd0);

    // Pattern decode: first match wins.
    always_comb
    begin
        if (in_data.touch_status == key1_pattern_reg)
        begin
            key_code = 2'd1;
        end
        else if (in_data.touch_status == key2_pattern_reg)
        begin
            key_code = 2'd2;
        end
        else if (in_data.touch_status == key3_pattern_reg)
        begin
            key_code = 2'd3;
        end
        else
        begin
            key_code = 2'd0;
        end
    end

    // Debounce and long-press machine; produces at most one push per scan word.
    always_comb
    begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        hold_count_next   = hold_count_reg;
        held_code_next    = held_code_reg;
        push_en           = 1'b0;
        push_code         = held_code_reg;

        unique case (phase_reg)
            PH_SETTLE:
            begin
                if (settle_count_reg <= 16'd1)
                begin
                    settle_count_next = 16'd0;
                    phase_next        = key_down ? PH_CAPTURE : PH_IDLE;
                end
                else
                begin
                    settle_count_next = settle_count_reg - 16'd1;
                end
            end
            PH_CAPTURE:
            begin
                if (key_down)
                begin
                    held_code_next  = {6'd0, key_code};
                    hold_count_next = long_press_ticks_reg;
                    phase_next      = PH_HOLD;
                end
                else
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_HOLD:
            begin
                if (key_down)
                begin
                    if (hold_count_reg != 16'd0)
                    begin
                        hold_count_next = hold_count_reg - 16'd1;
                        // Long press reached: queue the offset code.
                        if (hold_count_reg == 16'd1)
                        begin
                            held_code_next    = 8'({6'd0, key_code} + long_press_offset_reg);
                            push_en           = 1'b1;
                            push_code         = held_code_next;
                            phase_next        = PH_RELEASE;
                            settle_count_next = settle_ticks_reg;
                        end
                    end
                end
                else
                begin
                    // Short press released.
                    push_en           = 1'b1;
                    push_code         = held_code_reg;
                    phase_next        = PH_RELEASE;
                    settle_count_next = settle_ticks_reg;
                end
            end
            PH_RELEASE:
            begin
                if (settle_count_reg != 16'd0)
                begin
                    settle_count_next = settle_count_reg - 16'd1;
                    if (settle_count_reg == 16'd1)
                    begin
                        if (key_down)
                        begin
                            settle_count_next = settle_ticks_reg;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            // Held codes above the long-press offset get a release code.
                            if (held_code_reg > long_press_offset_reg)
                            begin
                                push_en   = 1'b1;
                                push_code = 8'(held_code_reg + release_offset_reg);
                            end
                        end
                    end
                end
                else if (!key_down)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (key_down)
                begin
                    phase_next        = PH_SETTLE;
                    settle_count_next = settle_ticks_reg;
                end
            end
        endcase
    end

    // Queue pointers and fill; a push into a full queue flushes it.
    assign push_ok = push_en && (fill_reg < fill_t'(kdq_pkg::QUEUE_DEPTH));
    assign pop_ok  = (fill_reg != fill_t'(0));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (is_pop)
        begin
            if (pop_ok)
            begin
                fill_next   = fill_reg - fill_t'(1);
                rd_ptr_next = (rd_ptr_reg == ptr_t'(kdq_pkg::QUEUE_DEPTH - 1))
                              ? ptr_t'(0) : rd_ptr_reg + ptr_t'(1);
            end
        end
        else if (push_en)
        begin
            if (push_ok)
            begin
                fill_next   = fill_reg + fill_t'(1);
                wr_ptr_next = (wr_ptr_reg == ptr_t'(kdq_pkg::QUEUE_DEPTH - 1))
                              ? ptr_t'(0) : wr_ptr_reg + ptr_t'(1);
            end
            else
            begin
                fill_next = fill_t'(0);
            end
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg      <= 16'd5;
            long_press_ticks_reg  <= 16'd100;
            key1_pattern_reg      <= 16'd1;
            key2_pattern_reg      <= 16'd2;
            key3_pattern_reg      <= 16'd4;
            long_press_offset_reg <= 8'd16;
            release_offset_reg    <= 8'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                kdq_pkg::REG_SETTLE_TICKS:      settle_ticks_reg      <= cfg_wdata;
                kdq_pkg::REG_LONG_PRESS_TICKS:  long_press_ticks_reg  <= cfg_wdata;
                kdq_pkg::REG_KEY1_PATTERN:      key1_pattern_reg      <= cfg_wdata;
                kdq_pkg::REG_KEY2_PATTERN:      key2_pattern_reg      <= cfg_wdata;
                kdq_pkg::REG_KEY3_PATTERN:      key3_pattern_reg      <= cfg_wdata;
                kdq_pkg::REG_LONG_PRESS_OFFSET: long_press_offset_reg <= cfg_wdata[7:0];
                kdq_pkg::REG_RELEASE_OFFSET:    release_offset_reg    <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // State update and control part of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            settle_count_reg <= 16'd0;
            hold_count_reg   <= 16'd0;
            held_code_reg    <= 8'd0;
            wr_ptr_reg       <= ptr_t'(0);
            rd_ptr_reg       <= ptr_t'(0);
            fill_reg         <= fill_t'(0);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!is_pop)
                begin
                    phase_reg        <= phase_next;
                    settle_count_reg <= settle_count_next;
                    hold_count_reg   <= hold_count_next;
                    held_code_reg    <= held_code_next;
                end
                wr_ptr_reg    <= wr_ptr_next;
                rd_ptr_reg    <= rd_ptr_next;
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the result word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            popped_valid_reg <= is_pop && pop_ok;
            code_reg         <= is_pop ? kdq_pkg::CODE_EMPTY : kdq_pkg::CODE_NONE;
            not_empty_reg    <= (fill_next != fill_t'(0));
            level_reg        <= 4'(fill_next);
        end
    end

    // Queue storage: written on a successful push, read at the head on every word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!is_pop && push_ok)
            begin
                queue_mem[wr_ptr_reg] <= push_code;
            end
            rd_data_reg <= queue_mem[rd_ptr_reg];
        end
    end

    assign out_valid                = out_valid_reg;
    assign out_data.popped_valid    = popped_valid_reg;
    assign out_data.popped_code     = popped_valid_reg ? rd_data_reg : code_reg;
    assign out_data.queue_not_empty = not_empty_reg;
    assign out_data.queue_level     = level_reg;

    // The fill count never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fill_t'(kdq_pkg::QUEUE_DEPTH))
        else $error("queue fill exceeds depth");

    // A successful pop lowers the fill by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_pop && pop_ok) |=> (fill_reg == $past(fill_reg) - fill_t'(1)))
        else $error("pop did not lower the fill by one");

    // Every accepted word leaves a result word waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result word");

    // A pop word never disturbs the scan machine.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_pop) |=> ((phase_reg == $past(phase_reg))
                                 && (settle_count_reg == $past(settle_count_reg))))
        else $error("pop word changed the scan state");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for key_debounce_long_press_queue_top: debounce, long-press codes
// and the key queue, predicted tick by tick. Depends on kdq_pkg and the top-level RTL only.
module tb_top;
    import kdq_pkg::*;

    // Index beyond the register map; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int RANDOM_WORDS_PER_PHASE = 55;
    localparam int RANDOM_PHASES = 8;

    typedef enum logic [2:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_SETTLE  = 3'd1,
        SCAN_CAPTURE = 3'd2,
        SCAN_HOLD    = 3'd3,
        SCAN_RELEASE = 3'd4
    } scan_phase_e;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [CFG_ADDR_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]  reg_value;
        in_word_t               word;
        bit                     fixed;
        out_word_t              result;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;

    // Shadow copy of the configuration registers.
    logic [15:0] settle_ticks_cfg;
    logic [15:0] long_ticks_cfg;
    logic [15:0] key_pattern [0:2];
    logic [7:0]  long_offset_cfg;
    logic [7:0]  release_offset_cfg;

    // Shadow copy of the scan machine and the key queue.
    scan_phase_e scan_phase;
    logic [15:0] settle_left;
    logic [15:0] hold_left;
    logic [7:0]  held_code;
    logic [7:0]  code_store [0:QUEUE_DEPTH-1];
    int          wr_pos;
    int          rd_pos;
    int          fill;

    out_word_t   expected_key_results [$];
    row_t        stimulus_rows [$];
    int          fail_count;
    int          burst_left;
    bit          hold_off_request;

    key_debounce_long_press_queue_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Key code for a full status word; earlier patterns win on a tie.
    function automatic logic [7:0] decode_touch(input logic [15:0] status);
        if (status == key_pattern[0])
            return 8'd1;
        if (status == key_pattern[1])
            return 8'd2;
        if (status == key_pattern[2])
            return 8'd3;
        return CODE_NONE;
    endfunction

    // A push into a full queue flushes it and loses the new code.
    function automatic void store_key_code(input logic [7:0] code);
        if (fill < QUEUE_DEPTH)
        begin
            code_store[wr_pos] = code;
            wr_pos = (wr_pos + 1) % QUEUE_DEPTH;
            fill++;
        end
        else
            fill = 0;
    endfunction

    // Advances the shadow state by one word and returns the result word it yields.
    function automatic out_word_t predict_key_result(input in_word_t word);
        out_word_t result;
        logic      down;
        result = '0;
        down = (word.touch_status[7:0] != 8'h00);
        if (word.mode == MODE_POP)
        begin
            if (fill > 0)
            begin
                fill--;
                result.popped_valid = 1'b1;
                result.popped_code = code_store[rd_pos];
                rd_pos = (rd_pos + 1) % QUEUE_DEPTH;
            end
            else
                result.popped_code = CODE_EMPTY;
        end
        else
        begin
            case (scan_phase)
                SCAN_SETTLE:
                begin
                    if (settle_left <= 16'd1)
                    begin
                        settle_left = 16'd0;
                        scan_phase = down ? SCAN_CAPTURE : SCAN_IDLE;
                    end
                    else
                        settle_left--;
                end
                SCAN_CAPTURE:
                begin
                    if (down)
                    begin
                        held_code = decode_touch(word.touch_status);
                        hold_left = long_ticks_cfg;
                        scan_phase = SCAN_HOLD;
                    end
                    else
                        scan_phase = SCAN_RELEASE;
                end
                SCAN_HOLD:
                begin
                    if (!down)
                    begin
                        store_key_code(held_code);
                        scan_phase = SCAN_RELEASE;
                        settle_left = settle_ticks_cfg;
                    end
                    else if (hold_left > 16'd0)
                    begin
                        hold_left--;
                        // The long-press code uses the key seen on this very tick.
                        if (hold_left == 16'd0)
                        begin
                            held_code = decode_touch(word.touch_status) + long_offset_cfg;
                            store_key_code(held_code);
                            scan_phase = SCAN_RELEASE;
                            settle_left = settle_ticks_cfg;
                        end
                    end
                end
                SCAN_RELEASE:
                begin
                    if (settle_left > 16'd0)
                    begin
                        settle_left--;
                        if (settle_left == 16'd0)
                        begin
                            if (down)
                                settle_left = settle_ticks_cfg;
                            else
                            begin
                                scan_phase = SCAN_IDLE;
                                if (held_code > long_offset_cfg)
                                    store_key_code(held_code + release_offset_cfg);
                            end
                        end
                    end
                    else if (!down)
                        scan_phase = SCAN_IDLE;
                end
                default:
                begin
                    scan_phase = SCAN_IDLE;
                    if (down)
                    begin
                        scan_phase = SCAN_SETTLE;
                        settle_left = settle_ticks_cfg;
                    end
                end
            endcase
        end
        result.queue_not_empty = (fill > 0);
        result.queue_level = 4'(fill);
        return result;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SETTLE_TICKS:      settle_ticks_cfg = value;
            REG_LONG_PRESS_TICKS:  long_ticks_cfg = value;
            REG_KEY1_PATTERN:      key_pattern[0] = value;
            REG_KEY2_PATTERN:      key_pattern[1] = value;
            REG_KEY3_PATTERN:      key_pattern[2] = value;
            REG_LONG_PRESS_OFFSET: long_offset_cfg = value[7:0];
            REG_RELEASE_OFFSET:    release_offset_cfg = value[7:0];
            default: ;
        endcase
    endfunction

    function automatic out_word_t make_result(input logic valid, input logic [7:0] code,
                                              input logic not_empty, input logic [3:0] level);
        out_word_t result;
        result.popped_valid = valid;
        result.popped_code = code;
        result.queue_not_empty = not_empty;
        result.queue_level = level;
        return result;
    endfunction

    function automatic void add_word_row(input logic mode, input logic [15:0] status,
                                         input bit fixed, input out_word_t result);
        row_t row;
        row.kind = ROW_WORD;
        row.reg_idx = '0;
        row.reg_value = '0;
        row.word.mode = mode;
        row.word.touch_status = status;
        row.fixed = fixed;
        row.result = result;
        stimulus_rows.push_back(row);
    endfunction

    function automatic void add_reg_row(input logic [CFG_ADDR_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
        row_t row;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_value = value;
        row.word = '0;
        row.fixed = 1'b0;
        row.result = '0;
        stimulus_rows.push_back(row);
    endfunction

    // Offers one word in bursts with random gaps, then records its expected result.
    task automatic offer_word(input in_word_t word, input bit fixed, input out_word_t result);
        out_word_t predicted;
        int        gap;
        begin
            gap = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 6);
            end
            burst_left--;
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= word;
            do
                @(posedge clk);
            while (!in_ready);
            predicted = predict_key_result(word);
            expected_key_results.push_back(fixed ? result : predicted);
        end
    endtask

    // Drops valid and waits until every expected word has come back.
    task automatic wait_until_idle();
        int guard;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            guard = 0;
            while (expected_key_results.size() != 0 && guard < 5000)
            begin
                @(posedge clk);
                guard++;
            end
            if (expected_key_results.size() != 0)
            begin
                $error("%0d result words never arrived", expected_key_results.size());
                fail_count++;
                expected_key_results.delete();
            end
            repeat (3) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_addr <= idx;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we <= 1'b0;
            apply_reg_write(idx, value);
        end
    endtask

    // Offsets go out with a random upper byte that the block must drop.
    task automatic configure_phase(input logic [15:0] settle, input logic [15:0] long_ticks,
                                   input logic [15:0] key1, input logic [15:0] key2,
                                   input logic [15:0] key3, input logic [7:0] long_offset,
                                   input logic [7:0] rel_offset);
        begin
            wait_until_idle();
            write_reg(REG_SETTLE_TICKS, settle);
            write_reg(REG_LONG_PRESS_TICKS, long_ticks);
            write_reg(REG_KEY1_PATTERN, key1);
            write_reg(REG_KEY2_PATTERN, key2);
            write_reg(REG_KEY3_PATTERN, key3);
            write_reg(REG_LONG_PRESS_OFFSET, {8'($urandom_range(0, 255)), long_offset});
            write_reg(REG_RELEASE_OFFSET, {8'($urandom_range(0, 255)), rel_offset});
        end
    endtask

    // Mostly press/hold/release sequences with bounce, plus pops and some pure noise.
    task automatic run_key_sequences(input int n_words, input int pop_pct);
        int          press_left;
        int          release_left;
        int          span;
        int          pick;
        logic [15:0] press_word;
        logic [15:0] status;
        in_word_t    word;
        begin
            press_left = 0;
            release_left = 0;
            press_word = '0;
            for (int i = 0; i < n_words; i++)
            begin
                word.mode = MODE_SCAN;
                pick = $urandom_range(0, 99);
                if (pick < pop_pct)
                begin
                    word.mode = MODE_POP;
                    status = 16'($urandom_range(0, 65535));
                end
                else if (pick >= 96)
                begin
                    word.mode = 1'($urandom_range(0, 1));
                    status = 16'($urandom_range(0, 65535));
                end
                else if (press_left > 0)
                begin
                    press_left--;
                    status = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                         : press_word;
                end
                else if (release_left > 0)
                begin
                    release_left--;
                    status = {8'($urandom_range(0, 255)), 8'h00};
                    if ($urandom_range(0, 11) == 0)
                        status = press_word;
                end
                else
                begin
                    // Start a new press, either short or past the long-press time.
                    pick = $urandom_range(0, 6);
                    if (pick < 6)
                        press_word = key_pattern[pick % 3];
                    else
                        press_word = 16'($urandom_range(0, 65535));
                    span = int'(settle_ticks_cfg) + int'(long_ticks_cfg) + 4;
                    if (span > 40)
                        span = 40;
                    press_left = $urandom_range(1, span);
                    span = int'(settle_ticks_cfg) + 3;
                    if (span > 30)
                        span = 30;
                    release_left = $urandom_range(0, span);
                    status = press_word;
                end
                word.touch_status = status;
                offer_word(word, 1'b0, '0);
            end
        end
    endtask

    // Receiver: stall segments of random density, and one long hold-off on request.
    initial
    begin : receiver
        int seg_left;
        int stall_pct;
        int hold_cycles;
        out_ready = 1'b0;
        seg_left = 0;
        stall_pct = 0;
        hold_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_cycles = 60;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 60);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        out_word_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_key_results.size() == 0)
            begin
                $error("unexpected result word %h", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_key_results.pop_front();
                if (out_data.popped_valid !== want.popped_valid)
                begin
                    $error("popped_valid: expected %0d, actual %0d",
                           want.popped_valid, out_data.popped_valid);
                    fail_count++;
                end
                if (out_data.popped_code !== want.popped_code)
                begin
                    $error("popped_code: expected %0h, actual %0h",
                           want.popped_code, out_data.popped_code);
                    fail_count++;
                end
                if (out_data.queue_not_empty !== want.queue_not_empty)
                begin
                    $error("queue_not_empty: expected %0d, actual %0d",
                           want.queue_not_empty, out_data.queue_not_empty);
                    fail_count++;
                end
                if (out_data.queue_level !== want.queue_level)
                begin
                    $error("queue_level: expected %0d, actual %0d",
                           want.queue_level, out_data.queue_level);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        bit          after_word;
        logic [15:0] settle;
        logic [15:0] long_ticks;
        logic [15:0] key1;
        logic [15:0] key2;
        logic [15:0] key3;
        logic [7:0]  long_offset;
        logic [7:0]  rel_offset;
        int          pop_pct;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        fail_count = 0;
        burst_left = 0;
        hold_off_request = 1'b0;

        // Shadow state matches the block after reset.
        settle_ticks_cfg = 16'd5;
        long_ticks_cfg = 16'd100;
        key_pattern[0] = 16'd1;
        key_pattern[1] = 16'd2;
        key_pattern[2] = 16'd4;
        long_offset_cfg = 8'd16;
        release_offset_cfg = 8'd16;
        scan_phase = SCAN_IDLE;
        settle_left = '0;
        hold_left = '0;
        held_code = '0;
        wr_pos = 0;
        rd_pos = 0;
        fill = 0;
        foreach (code_store[i])
            code_store[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: empty pop and idle ticks at reset values first.
        add_word_row(MODE_POP, 16'hFFFF, 1'b1, make_result(1'b0, CODE_EMPTY, 1'b0, 4'd0));
        add_word_row(MODE_SCAN, 16'h0000, 1'b1, make_result(1'b0, CODE_NONE, 1'b0, 4'd0));
        add_word_row(MODE_SCAN, 16'hFF00, 1'b1, make_result(1'b0, CODE_NONE, 1'b0, 4'd0));
        add_reg_row(REG_SETTLE_TICKS, 16'd1);
        add_reg_row(REG_LONG_PRESS_TICKS, 16'd3);
        add_reg_row(REG_KEY1_PATTERN, 16'hFFFF);
        add_reg_row(REG_KEY2_PATTERN, 16'h8001);
        add_reg_row(REG_KEY3_PATTERN, 16'h00FF);
        add_reg_row(REG_LONG_PRESS_OFFSET, 16'hA510);
        add_reg_row(REG_RELEASE_OFFSET, 16'h00F8);
        add_reg_row(REG_UNMAPPED, 16'h1234);
        // Short press of key 1.
        add_word_row(MODE_SCAN, 16'hFFFF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'hFFFF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'hFFFF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h0000, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h0000, 1'b0, '0);
        // Long press of key 3 whose code changes on the last hold tick, a bounce
        // in release-settle, then a release code that wraps past 255.
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h8001, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h8001, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h0100, 1'b0, '0);
        // Drain the queue and pop once more when empty.
        add_word_row(MODE_POP, 16'h0000, 1'b0, '0);
        add_word_row(MODE_POP, 16'h5A5A, 1'b0, '0);
        add_word_row(MODE_POP, 16'hFFFF, 1'b0, '0);
        add_word_row(MODE_POP, 16'h0000, 1'b1, make_result(1'b0, CODE_EMPTY, 1'b0, 4'd0));
        // A press that vanishes in the capture phase.
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h00FF, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h0000, 1'b0, '0);
        add_word_row(MODE_SCAN, 16'h0000, 1'b0, '0);

        after_word = 1'b1;
        foreach (stimulus_rows[i])
        begin
            if (stimulus_rows[i].kind == ROW_REG)
            begin
                if (after_word)
                    wait_until_idle();
                after_word = 1'b0;
                write_reg(stimulus_rows[i].reg_idx, stimulus_rows[i].reg_value);
            end
            else
            begin
                after_word = 1'b1;
                offer_word(stimulus_rows[i].word, stimulus_rows[i].fixed,
                           stimulus_rows[i].result);
            end
        end

        // Random phases, each under its own register settings.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            key1 = 16'($urandom_range(0, 65535));
            key2 = 16'($urandom_range(0, 65535));
            key3 = 16'($urandom_range(0, 65535));
            long_offset = 8'($urandom_range(0, 255));
            rel_offset = 8'($urandom_range(0, 255));
            settle = 16'($urandom_range(0, 4));
            long_ticks = 16'($urandom_range(1, 8));
            pop_pct = 15;
            case (p)
                0:
                begin
                    // Zero settle time, zero offset, all-ones and all-zeros patterns.
                    settle = 16'd0;
                    long_ticks = 16'd2;
                    key1 = 16'hFFFF;
                    key3 = 16'h0000;
                    long_offset = 8'h00;
                    rel_offset = 8'hFF;
                end
                1:
                begin
                    // No long press at all; rare pops so the queue overflows.
                    settle = 16'd2;
                    long_ticks = 16'd0;
                    long_offset = 8'hFF;
                    rel_offset = 8'h00;
                    pop_pct = 3;
                end
                2:
                begin
                    // Two keys share a pattern; the first one must win.
                    settle = 16'd1;
                    long_ticks = 16'd1;
                    key2 = key1;
                    pop_pct = 20;
                end
                3:
                begin
                    settle = 16'd3;
                    long_ticks = 16'hFFFF;
                end
                4:
                begin
                    pop_pct = 2;
                end
                5:
                begin
                    key2 = {8'($urandom_range(0, 255)), 8'h00};
                    long_offset = 8'h01;
                    pop_pct = 25;
                end
                6:
                begin
                    settle = 16'd1;
                    long_ticks = 16'd4;
                    pop_pct = 10;
                end
                default:
                begin
                    // Longest settle time last: the machine never leaves settle.
                    settle = 16'hFFFF;
                    long_ticks = 16'd1;
                    pop_pct = 10;
                end
            endcase
            configure_phase(settle, long_ticks, key1, key2, key3, long_offset, rel_offset);
            // The long hold-off starts once the sender is offering words again.
            if (p == 4)
                hold_off_request = 1'b1;
            run_key_sequences(RANDOM_WORDS_PER_PHASE, pop_pct);
        end

        wait_until_idle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
sv/kdq_pkg.sv
sv/key_debounce_long_press_queue_top.sv
dv/tb_top.sv
